FILE: sv/bounded_deque_top_assert.svh
// Assertion macros shared by the bounded deque RTL.
// Depends on i_clk and i_rst_n being present in the module that uses them.
`ifndef BOUNDED_DEQUE_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define BDQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Implication checked at every clock edge out of reset
`define BDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/bdq_pkg.sv
// Shared types and constants of the bounded deque.
// No dependencies; used by the front, back and top modules and the testbench.
package bdq_pkg;

    // Default ring size
    localparam int DEPTH_DEF = 16;

    // Queue depths between the parts of the block
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Field widths
    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST       = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Input request
    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] value;
    } t_in;

    // Result item
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] value_res;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } t_res;

    // Classified command passed from front to back
    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_POP,
        KIND_LIST
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic                     at_front;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // Back-end engine states
    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

endpackage

FILE: sv/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdq_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bdq_fifo.sv
// Small register queue with full, empty and fill count.
// No dependencies; carries any packed payload as a bit vector.
module bdq_fifo #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  logic [W-1:0]           i_wdata,
    input  logic                   i_rd,
    output logic [W-1:0]           o_rdata,
    output logic                   o_empty,
    output logic                   o_full,
    output logic [$clog2(D+1)-1:0] o_count
);

    localparam int AW = $clog2(D);
    localparam int CW = $clog2(D + 1);

    logic [W-1:0]  r_mem [D];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wp, n_rp;
    logic [CW-1:0] n_cnt;
    logic          wr_ok, rd_ok;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(D));
    assign o_count = r_cnt;
    assign o_rdata = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    // Advance pointers with wrap, track fill
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_ok) begin
            n_wp = (r_wp == AW'(D - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_ok) begin
            n_rp = (r_rp == AW'(D - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

FILE: sv/bdq_front.sv
// Front end: accepts requests, classifies them and queues commands.
// Depends on bdq_pkg and bdq_fifo.
module bdq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  bdq_pkg::t_in  i_item,
    input  logic          i_cmd_pop,
    output bdq_pkg::t_cmd o_cmd,
    output logic          o_cmd_empty
);

    localparam int CMD_W = $bits(bdq_pkg::t_cmd);

    bdq_pkg::t_cmd         cmd;
    logic                  cmd_valid;
    logic [CMD_W-1:0]      cmd_bits;
    logic [$clog2(bdq_pkg::CMD_DEPTH+1)-1:0] cmd_count;

    // Decode operation; undefined codes are dropped
    always_comb begin
        cmd_valid    = 1'b1;
        cmd.kind     = bdq_pkg::KIND_PUSH;
        cmd.at_front = 1'b0;
        cmd.value    = i_item.value;
        unique case (i_item.operation)
            bdq_pkg::OP_PUSH_BACK: begin
                cmd.kind = bdq_pkg::KIND_PUSH;
            end
            bdq_pkg::OP_PUSH_FRONT: begin
                cmd.at_front = 1'b1;
            end
            bdq_pkg::OP_POP_FRONT: begin
                cmd.kind     = bdq_pkg::KIND_POP;
                cmd.at_front = 1'b1;
            end
            bdq_pkg::OP_POP_BACK: begin
                cmd.kind = bdq_pkg::KIND_POP;
            end
            bdq_pkg::OP_LIST: begin
                cmd.kind = bdq_pkg::KIND_LIST;
            end
            default: begin
                cmd_valid = 1'b0;
            end
        endcase
    end

    // Command queue toward the back end
    bdq_fifo #(
        .W (CMD_W),
        .D (bdq_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push && cmd_valid),
        .i_wdata (cmd),
        .i_rd    (i_cmd_pop),
        .o_rdata (cmd_bits),
        .o_empty (o_cmd_empty),
        .o_full  (full),
        .o_count (cmd_count)
    );

    assign o_cmd = bdq_pkg::t_cmd'(cmd_bits);

    `include "bounded_deque_top_assert.svh"

    `BDQ_ASSERT_ALWAYS(a_cmd_count_bound, cmd_count <= ($bits(cmd_count))'(bdq_pkg::CMD_DEPTH), "command queue overfilled")
    `BDQ_ASSERT_IMPL(a_pop_nonempty, i_cmd_pop, !o_cmd_empty, "command popped from empty queue")
    `BDQ_ASSERT_IMPL(a_full_holds, full && !i_cmd_pop, ##1 full, "command queue lost an entry")

endmodule

FILE: sv/bdq_back.sv
// Back end: ring pointers, element storage and result generation.
// Depends on bdq_pkg and bdq_ram.
module bdq_back #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bdq_pkg::t_cmd                 i_cmd,
    input  logic                          i_cmd_empty,
    output logic                          o_cmd_pop,
    input  logic [bdq_pkg::OUT_CNT_W-1:0] i_out_count,
    output logic                          o_res_wr,
    output bdq_pkg::t_res                 o_res
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int OW  = (CW > bdq_pkg::OCC_W) ? CW : bdq_pkg::OCC_W;
    localparam int OCW = bdq_pkg::OUT_CNT_W;

    bdq_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_pend, n_pend;
    logic            r_pend_last, n_pend_last;
    logic [bdq_pkg::OCC_W-1:0] r_pend_occ, n_pend_occ;

    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [bdq_pkg::DATA_W-1:0] ram_rdata;
    logic                      is_full, is_empty;
    logic [AW-1:0]             front_dec, front_inc;

    // Ring position of front plus an offset below twice the depth
    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Element count as the 5-bit occupancy field
    function automatic logic [bdq_pkg::OCC_W-1:0] to_occ(input logic [CW-1:0] c);
        logic [OW-1:0] w;
        w = OW'(c);
        return w[bdq_pkg::OCC_W-1:0];
    endfunction

    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;

    // Next state, pointer updates and result generation
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_pend_occ  = r_pend_occ;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = ring_pos(r_front, r_count);
        ram_raddr   = ring_pos(r_front, r_idx);
        o_res_wr    = 1'b0;
        o_res.status    = bdq_pkg::STAT_OK;
        o_res.value_res = ram_rdata;
        o_res.occupancy = r_pend_occ;
        o_res.last      = r_pend_last;

        // Deliver data of the read issued last cycle
        if (r_pend) begin
            o_res_wr = 1'b1;
        end

        unique case (r_state)
            bdq_pkg::S_IDLE: begin
                if (!r_pend && !i_cmd_empty && (i_out_count < OCW'(bdq_pkg::OUT_DEPTH))) begin
                    o_cmd_pop  = 1'b1;
                    o_res.last = 1'b1;
                    unique case (i_cmd.kind)
                        bdq_pkg::KIND_PUSH: begin
                            o_res_wr        = 1'b1;
                            o_res.value_res = i_cmd.value;
                            if (is_full) begin
                                o_res.status    = bdq_pkg::STAT_FULL;
                                o_res.occupancy = to_occ(r_count);
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + 1'b1;
                                o_res.occupancy = to_occ(r_count + 1'b1);
                                if (i_cmd.at_front) begin
                                    ram_waddr = front_dec;
                                    n_front   = front_dec;
                                end
                            end
                        end
                        bdq_pkg::KIND_POP: begin
                            if (is_empty) begin
                                o_res_wr        = 1'b1;
                                o_res.status    = bdq_pkg::STAT_EMPTY;
                                o_res.value_res = '0;
                                o_res.occupancy = '0;
                            end else begin
                                ram_re      = 1'b1;
                                n_pend      = 1'b1;
                                n_pend_last = 1'b1;
                                n_pend_occ  = to_occ(r_count - 1'b1);
                                n_count     = r_count - 1'b1;
                                if (i_cmd.at_front) begin
                                    ram_raddr = r_front;
                                    n_front   = front_inc;
                                end else begin
                                    ram_raddr = ring_pos(r_front, r_count - 1'b1);
                                end
                            end
                        end
                        bdq_pkg::KIND_LIST: begin
                            if (is_empty) begin
                                o_res_wr        = 1'b1;
                                o_res.status    = bdq_pkg::STAT_EMPTY;
                                o_res.value_res = '0;
                                o_res.occupancy = '0;
                            end else begin
                                n_state = bdq_pkg::S_LIST;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                            o_res_wr = 1'b0;
                        end
                    endcase
                end
            end
            bdq_pkg::S_LIST: begin
                // Stream one element per cycle while the result queue has room
                if (((OCW+1)'(i_out_count) + (OCW+1)'(r_pend)) <
                    (OCW+1)'(bdq_pkg::OUT_DEPTH)) begin
                    ram_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_occ  = to_occ(r_count);
                    n_pend_last = (r_idx + 1'b1 == r_count);
                    n_idx       = r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_count) begin
                        n_state = bdq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = bdq_pkg::S_IDLE;
            end
        endcase
    end

    // State and pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    // Hold tags of the read in flight
    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        r_pend_occ  <= n_pend_occ;
    end

    // Element storage
    bdq_ram #(
        .W (bdq_pkg::DATA_W),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    `include "bounded_deque_top_assert.svh"

    `BDQ_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(DEPTH), "element count exceeds depth")
    `BDQ_ASSERT_IMPL(a_no_overflow, o_res_wr, i_out_count < OCW'(bdq_pkg::OUT_DEPTH), "result written into full queue")
    `BDQ_ASSERT_IMPL(a_list_nonempty, r_state == bdq_pkg::S_LIST, r_count != '0 && r_idx < r_count, "list walk out of range")
    `BDQ_ASSERT_IMPL(a_read_delivers, ram_re, ##1 (r_pend && o_res_wr), "issued read not delivered")

endmodule

FILE: sv/bounded_deque_top.sv
// Bounded double-ended queue of signed 32-bit values: top level.
// Depends on bdq_pkg, bdq_front, bdq_back and bdq_fifo.
//
// Usage:
//   Requests enter through a queue-style port: i_item is taken at a clock
//   edge with push high and full low. Operation codes: push back, push
//   front, pop front, pop back, list. Undefined codes are taken and dropped.
//   Results leave through a queue-style port: o_result is valid while empty
//   is low and is taken at an edge with pop high.
// Order: a push result is written into the result queue as the back end takes
//   its command; a pop result follows the registered read of the storage RAM;
//   a list of N elements streams one element per cycle while the result queue
//   has room, the final one with last set.
// Throughput: pushes run one per cycle while the result queue has room; a pop
//   holds the next command until its data from the RAM's registered read port
//   is delivered; a single command engine in the back end serves requests in order.
// Reset (synchronous, i_rst_n low) empties the deque and both queues; the
//   element storage is not cleared and needs no clearing pass.
// When the receiver stalls the four-entry result queue fills, the back end
//   halts, the two-entry request queue fills and full rises; nothing is lost.
module bounded_deque_top #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  bdq_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output bdq_pkg::t_res o_result
);

    localparam int RES_W = $bits(bdq_pkg::t_res);

    bdq_pkg::t_cmd                 cmd;
    logic                          cmd_empty;
    logic                          cmd_pop;
    logic                          res_wr;
    bdq_pkg::t_res                 res;
    logic [RES_W-1:0]              res_bits;
    logic [bdq_pkg::OUT_CNT_W-1:0] out_count;
    logic                          out_full;

    // Accept and classify requests
    bdq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty)
    );

    // Execute commands against the ring
    bdq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_res_wr    (res_wr),
        .o_res       (res)
    );

    // Result queue toward the receiver
    bdq_fifo #(
        .W (RES_W),
        .D (bdq_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (res),
        .i_rd    (pop),
        .o_rdata (res_bits),
        .o_empty (empty),
        .o_full  (out_full),
        .o_count (out_count)
    );

    assign o_result = bdq_pkg::t_res'(res_bits);

    `include "bounded_deque_top_assert.svh"

    `BDQ_ASSERT_IMPL(a_full_matches_count, out_full, out_count == bdq_pkg::OUT_CNT_W'(bdq_pkg::OUT_DEPTH), "result queue full flag mismatch")
    `BDQ_ASSERT_IMPL(a_empty_holds, empty && !res_wr, ##1 empty, "result appeared without a write")
    `BDQ_ASSERT_ALWAYS(a_status_code, o_result.status == bdq_pkg::STAT_OK || o_result.status == bdq_pkg::STAT_EMPTY || o_result.status == bdq_pkg::STAT_FULL || empty, "bad status delivered")

endmodule

FILE: sim/tb_bounded_deque_top.sv
// Self-checking testbench of bounded_deque_top: directed and random requests
// against a ring model of the deque, with random idling on both sides.
// Depends on bdq_pkg and the bounded_deque_top RTL.
module tb_bounded_deque_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = bdq_pkg::DEPTH_DEF;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = DEPTH + 16;
    localparam int PHASE_ITEMS  = 100;

    // Codes the block takes and drops
    localparam logic [bdq_pkg::OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [bdq_pkg::OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          push    = 1'b0;
    logic          pop     = 1'b0;
    bdq_pkg::t_in  i_item  = '0;
    logic          full;
    logic          empty;
    bdq_pkg::t_res o_result;

    // Requests waiting for the driver and results the deque still owes
    bdq_pkg::t_in  pending_reqs[$];
    bdq_pkg::t_res due_results[$];

    // Ring model of the deque
    logic signed [bdq_pkg::DATA_W-1:0] ring [DEPTH];
    int    ring_head  = 0;
    int    ring_count = 0;

    t_idle_mode idle_mode = IDLE_NONE;
    bit    req_taken   = 1'b0;
    int    stall_count = 0;
    int    error_count = 0;

    bounded_deque_top #(.DEPTH(DEPTH)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic bit chance(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SEND: return chance(88);
            IDLE_BOTH: return chance(37);
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECV: return chance(88);
            IDLE_BOTH: return chance(37);
            default:   return 1'b0;
        endcase
    endfunction

    function automatic logic signed [bdq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(9, 0))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_request(input logic [bdq_pkg::OP_W-1:0] op,
                               input logic signed [bdq_pkg::DATA_W-1:0] val);
        bdq_pkg::t_in req;
        req.operation = op;
        req.value     = val;
        pending_reqs.push_back(req);
    endtask

    // Advance the ring model by one request and queue the results it owes
    task automatic apply_request(input bdq_pkg::t_in req);
        bdq_pkg::t_res r;
        int   pos;
        int   i;
        r = '0;
        case (req.operation)
            bdq_pkg::OP_PUSH_BACK, bdq_pkg::OP_PUSH_FRONT: begin
                r.value_res = req.value;
                r.last      = 1'b1;
                if (ring_count >= DEPTH) begin
                    r.status = bdq_pkg::STAT_FULL;
                end else begin
                    if (req.operation == bdq_pkg::OP_PUSH_BACK) begin
                        pos = (ring_head + ring_count) % DEPTH;
                    end else begin
                        ring_head = (ring_head + DEPTH - 1) % DEPTH;
                        pos       = ring_head;
                    end
                    ring[pos] = req.value;
                    ring_count++;
                    r.status = bdq_pkg::STAT_OK;
                end
                r.occupancy = bdq_pkg::OCC_W'(ring_count);
                due_results.push_back(r);
            end
            bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
                r.last = 1'b1;
                if (ring_count == 0) begin
                    r.status = bdq_pkg::STAT_EMPTY;
                end else begin
                    if (req.operation == bdq_pkg::OP_POP_FRONT) begin
                        pos       = ring_head;
                        ring_head = (ring_head + 1) % DEPTH;
                    end else begin
                        pos = (ring_head + ring_count - 1) % DEPTH;
                    end
                    r.value_res = ring[pos];
                    ring_count--;
                    r.status = bdq_pkg::STAT_OK;
                end
                r.occupancy = bdq_pkg::OCC_W'(ring_count);
                due_results.push_back(r);
            end
            bdq_pkg::OP_LIST: begin
                if (ring_count == 0) begin
                    r.status = bdq_pkg::STAT_EMPTY;
                    r.last   = 1'b1;
                    due_results.push_back(r);
                end else begin
                    for (i = 0; i < ring_count; i++) begin
                        r.status    = bdq_pkg::STAT_OK;
                        r.value_res = ring[(ring_head + i) % DEPTH];
                        r.occupancy = bdq_pkg::OCC_W'(ring_count);
                        r.last      = (i + 1 == ring_count);
                        due_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Random walk of occupancy: push-heavy and pop-heavy stretches alternate
    // so the deque swings between empty and full
    task automatic add_random_requests(input int count);
        int  made;
        int  run_left;
        bit  filling;
        int  roll;
        made     = 0;
        run_left = 0;
        filling  = 1'b1;
        while (made < count) begin
            if (run_left == 0) begin
                filling  = ~filling;
                run_left = $urandom_range(30, 8);
            end
            run_left--;
            roll = $urandom_range(99, 0);
            if (roll < 3) begin
                add_request(bdq_pkg::OP_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST)),
                            $urandom);
                continue;
            end
            if (roll < 9) begin
                add_request(bdq_pkg::OP_LIST, $urandom);
            end else if ((roll < 75) == filling) begin
                add_request(chance(50) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT,
                            pick_value());
            end else begin
                add_request(chance(50) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK,
                            $urandom);
            end
            made++;
        end
    endtask

    // Driver: hold a request until it is taken, then offer the next or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || req_taken) begin
            if (pending_reqs.size() != 0 && !sender_idles()) begin
                i_item <= pending_reqs.pop_front();
                push   <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: stall at random
    always @(negedge i_clk) begin
        pop <= i_rst_n && !receiver_stalls();
    end

    // Monitor: predict on each taken request, check each taken result
    always @(posedge i_clk) begin
        bdq_pkg::t_res want;
        bit   moved;
        req_taken = i_rst_n && push && !full;
        moved     = req_taken;
        if (req_taken) begin
            apply_request(i_item);
        end
        if (i_rst_n && pop && !empty) begin
            moved = 1'b1;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", o_result));
            end else begin
                want = due_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_result.status, want.status));
                if (o_result.value_res !== want.value_res)
                    report_mismatch($sformatf("value_res %0d, want %0d",
                                              o_result.value_res, want.value_res));
                if (o_result.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, want %0d",
                                              o_result.occupancy, want.occupancy));
                if (o_result.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b",
                                              o_result.last, want.last));
            end
        end
        // Watchdog: count cycles with work outstanding and nothing moving
        if (moved || !(pending_reqs.size() != 0 || push || due_results.size() != 0))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("** bounded_deque_top: FAILED **");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int i;

        // Empty deque: pops and list report empty; reserved codes are dropped
        add_request(bdq_pkg::OP_POP_FRONT, $urandom);
        add_request(bdq_pkg::OP_POP_BACK, $urandom);
        add_request(bdq_pkg::OP_LIST, $urandom);
        for (i = OP_RSVD_FIRST; i <= OP_RSVD_LAST; i++)
            add_request(i[bdq_pkg::OP_W-1:0], $urandom);
        // Extremes at both ends, then fill to the bound
        add_request(bdq_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
        add_request(bdq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        add_request(bdq_pkg::OP_LIST, $urandom);
        for (i = 2; i < DEPTH; i++)
            add_request(i[0] ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK, pick_value());
        // Full deque: refused pushes, then a full-length list
        add_request(bdq_pkg::OP_PUSH_BACK, -32'sd1);
        add_request(bdq_pkg::OP_PUSH_FRONT, 32'sd0);
        add_request(bdq_pkg::OP_LIST, $urandom);
        add_random_requests(PHASE_ITEMS);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the idling phases, each on its own batch
        while (pending_reqs.size() != 0) @(posedge i_clk);
        idle_mode = IDLE_SEND;
        add_random_requests(PHASE_ITEMS);
        while (pending_reqs.size() != 0) @(posedge i_clk);
        idle_mode = IDLE_RECV;
        add_random_requests(PHASE_ITEMS);
        while (pending_reqs.size() != 0) @(posedge i_clk);
        idle_mode = IDLE_BOTH;
        add_random_requests(PHASE_ITEMS);
        while (pending_reqs.size() != 0) @(posedge i_clk);

        // Drain outstanding results, then watch for strays
        idle_mode = IDLE_NONE;
        while (pending_reqs.size() != 0 || push || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));

        if (error_count == 0) begin
            $display("** bounded_deque_top: PASSED **");
        end else begin
            $display("** bounded_deque_top: FAILED **");
        end
        $finish;
    end

endmodule
